// ===== src/urxf_pkg.sv =====
// Shared types, constants and helper functions for the UART receiver with ring FIFO.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package urxf_pkg;

  // Ring FIFO geometry
  localparam int unsigned RING_DEPTH = 1024;
  localparam int unsigned PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // Field and register widths
  localparam int unsigned FIFO_CNT_W = 10;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BIT_IDX_W  = 3;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned TICK_W     = 17;

  // APB register map: 32-bit words; only word 0 holds a register (the bit period)
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_BIT_PERIOD = '0;

  // Bit timing
  localparam int unsigned PERIOD_MIN      = 3;
  localparam int unsigned PERIOD_RST      = 5208;
  localparam int unsigned START_RST       = PERIOD_RST + PERIOD_RST / 3;
  // floor(p / 3) == (p * DIV3_MUL) >> DIV3_SHIFT for every 16-bit p
  localparam int unsigned DIV3_MUL        = 43691;
  localparam int unsigned DIV3_SHIFT      = 17;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_STOP = 2'd2
  } urxf_phase_e;

  // Frame receiver status toward the ring FIFO and the output stage
  typedef struct packed {
    logic              done;
    logic [BYTE_W-1:0] data;
    logic              busy;
  } urxf_frame_t;

  // Ring FIFO status for the tick just taken
  typedef struct packed {
    logic             pop_ok;
    logic             drop;
    logic [PTR_W-1:0] count;
  } urxf_ring_t;

  // Clamp the programmed period to the shortest usable one
  function automatic logic [PERIOD_W-1:0] period_used(input logic [PERIOD_W-1:0] raw);
    return (raw < PERIOD_W'(PERIOD_MIN)) ? PERIOD_W'(PERIOD_MIN) : raw;
  endfunction

  // Delay from the start edge to the sample point of data bit 0, p/3 into that bit: p + p/3
  function automatic logic [TICK_W-1:0] start_delay(input logic [PERIOD_W-1:0] p);
    logic [2*PERIOD_W-1:0] prod;
    prod = p * PERIOD_W'(DIV3_MUL);
    return TICK_W'(p) + TICK_W'(prod >> DIV3_SHIFT);
  endfunction

endpackage

`default_nettype wire

// ===== src/urxf_frame.sv =====
// 8N1 frame receiver: start-edge detect, bit timing and LSB-first shift register.
// Depends on urxf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urxf_frame (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          level_i,
  input  logic [urxf_pkg::PERIOD_W-1:0] period_i,
  input  logic [urxf_pkg::TICK_W-1:0]   start_i,
  output urxf_pkg::urxf_frame_t         frame_o
);
  import urxf_pkg::*;

  urxf_phase_e            phase_q, phase_d;
  logic [TICK_W-1:0]      tick_q, tick_d, tick_dec;
  logic [BIT_IDX_W-1:0]   bit_q, bit_d;
  logic [BYTE_W-1:0]      shift_q, shift_d;
  logic                   last_q;
  logic                   fall;
  logic                   expire;
  logic                   done;

  assign fall     = last_q & ~level_i;
  assign tick_dec = tick_q - TICK_W'(1);
  assign expire   = (tick_dec == '0);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (fall) phase_d = PH_DATA;
      end
      PH_DATA: begin
        if (expire && bit_q == BIT_IDX_W'(BYTE_W - 1)) phase_d = PH_STOP;
      end
      PH_STOP: begin
        if (expire) phase_d = PH_IDLE;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Timer, bit counter and shift register
  always_comb begin
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    done    = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (fall) begin
          tick_d  = start_i;
          bit_d   = '0;
          shift_d = '0;
        end
      end
      PH_DATA: begin
        tick_d = tick_dec;
        if (expire) begin
          shift_d[bit_q] = level_i;
          tick_d         = TICK_W'(period_i);
          bit_d          = bit_q + BIT_IDX_W'(1);
        end
      end
      PH_STOP: begin
        tick_d = tick_dec;
        done   = expire;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      last_q  <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      last_q  <= level_i;
    end
  end

  assign frame_o = '{done: step_i & done, data: shift_q, busy: (phase_d != PH_IDLE)};

endmodule

`default_nettype wire

// ===== src/urxf_ring.sv =====
// Ring FIFO of received bytes: byte memory with registered read, pointers and fill count.
// Depends on urxf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module urxf_ring (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        pop_i,
  input  logic                        push_i,
  input  logic [urxf_pkg::BYTE_W-1:0] wdata_i,
  output urxf_pkg::urxf_ring_t        ring_o,
  output logic [urxf_pkg::BYTE_W-1:0] rdata_o
);
  import urxf_pkg::*;

  logic [BYTE_W-1:0] mem_q [RING_DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic [PTR_W-1:0]  rd_q, rd_d;
  logic [PTR_W-1:0]  wr_q, wr_d;
  logic [PTR_W-1:0]  cnt_q, cnt_d, cnt_pop;
  logic              pop_ok;
  logic              push_ok;
  logic              drop;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Pop goes first, so a pop frees room for a byte finished on the same tick
  assign pop_ok  = step_i & pop_i & (cnt_q != '0);
  assign cnt_pop = cnt_q - PTR_W'(pop_ok);
  assign drop    = step_i & push_i & (cnt_pop == PTR_W'(RING_DEPTH - 1));
  assign push_ok = step_i & push_i & ~drop;

  assign rd_d  = pop_ok  ? next_ptr(rd_q) : rd_q;
  assign wr_d  = push_ok ? next_ptr(wr_q) : wr_q;
  assign cnt_d = cnt_pop + PTR_W'(push_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  // Read and write never hit the same entry on one tick: a pop needs a non-empty FIFO
  always_ff @(posedge clk_i) begin
    if (push_ok) mem_q[wr_q] <= wdata_i;
    if (pop_ok) rdata_q <= mem_q[rd_q];
  end

  assign ring_o  = '{pop_ok: pop_ok, drop: drop, count: cnt_d};
  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/uart_receiver_with_ring_fifo.sv =====
// Top level of the 8N1 UART receiver with ring FIFO: APB register, frame receiver, FIFO.
// Depends on urxf_pkg, urxf_frame and urxf_ring.
`timescale 1ns / 1ps
`default_nettype none

// Each input word is one sample tick of the receive line plus a pop request, and each
// produces exactly one result word in the next cycle: the popped byte (or zero with
// out_valid low when nothing was popped), the fill count after the tick, a drop flag for
// a byte lost to a full FIFO, and whether a frame is in progress. The block takes one word
// per clock as long as the result side keeps up; the byte comes from the registered
// read port of the byte memory, and the result register lets a new word in while the last
// result is being taken. A falling line edge while idle starts a frame; data bit 0 is
// sampled bit_period + bit_period/3 ticks later and each further bit one period after
// that, LSB first, then the stop bit is waited out unchecked. The FIFO holds at most
// RING_DEPTH - 1 bytes and a pop on the same tick makes room for a finishing byte. The byte
// memory needs no clearing pass after reset. bit_period (APB offset 0x0, low 16 bits,
// values below 3 act as 3) must be written only while no word is in flight.
module uart_receiver_with_ring_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [urxf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [urxf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [urxf_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  // input word
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            rx_level_i,
  input  logic                            pop_req_i,
  // result word
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output logic                            out_valid_o,
  output logic [urxf_pkg::BYTE_W-1:0]     out_byte_o,
  output logic [urxf_pkg::FIFO_CNT_W-1:0] fifo_count_o,
  output logic                            dropped_o,
  output logic                            rx_busy_o
);
  import urxf_pkg::*;

  logic [PERIOD_W-1:0]  bit_period_q;
  logic [PERIOD_W-1:0]  period_used_q;
  logic [TICK_W-1:0]    start_q;
  logic [PERIOD_W-1:0]  wr_period;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  logic                 accept;
  urxf_frame_t          frame;
  urxf_ring_t           ring;
  logic [BYTE_W-1:0]    rdata;

  logic                 res_vld_q;
  logic                 pop_q;
  logic                 drop_q;
  logic                 busy_q;
  logic [PTR_W-1:0]     cnt_q;

  // ---------------------------------------------------------------------------
  // Configuration register: keep the clamped period and the start delay ready so
  // the frame receiver never computes them on the sample path
  // ---------------------------------------------------------------------------
  assign reg_idx   = paddr[APB_ADDR_W-1:2];
  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite & pready;
  assign wr_period = pwdata[PERIOD_W-1:0];

  always_comb begin
    unique case (reg_idx)
      REG_BIT_PERIOD: prdata = APB_DATA_W'(bit_period_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q  <= PERIOD_W'(PERIOD_RST);
      period_used_q <= PERIOD_W'(PERIOD_RST);
      start_q       <= TICK_W'(START_RST);
    end else if (cfg_wr && reg_idx == REG_BIT_PERIOD) begin
      bit_period_q  <= wr_period;
      period_used_q <= period_used(wr_period);
      start_q       <= start_delay(period_used(wr_period));
    end
  end

  // ---------------------------------------------------------------------------
  // Input handshake: take a word whenever the result register is free or drains
  // this cycle
  // ---------------------------------------------------------------------------
  assign in_ready_o = ~res_vld_q | res_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  urxf_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .level_i  (rx_level_i),
    .period_i (period_used_q),
    .start_i  (start_q),
    .frame_o  (frame)
  );

  urxf_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (accept),
    .pop_i   (pop_req_i),
    .push_i  (frame.done),
    .wdata_i (frame.data),
    .ring_o  (ring),
    .rdata_o (rdata)
  );

  // ---------------------------------------------------------------------------
  // Result register: status is captured here, the popped byte arrives from the
  // memory read register in the same cycle and holds until the next word
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      res_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pop_q  <= ring.pop_ok;
      drop_q <= ring.drop;
      cnt_q  <= ring.count;
      busy_q <= frame.busy;
    end
  end

  assign res_valid_o  = res_vld_q;
  assign out_valid_o  = pop_q;
  assign out_byte_o   = pop_q ? rdata : '0;
  assign fifo_count_o = FIFO_CNT_W'(cnt_q);
  assign dropped_o    = drop_q;
  assign rx_busy_o    = busy_q;

endmodule

`default_nettype wire

// ===== src/urxf_checker.sv =====
// Port-level checker for the UART receiver with ring FIFO, bound to the top level.
// Depends on urxf_pkg and uart_receiver_with_ring_fifo.
`timescale 1ns / 1ps
`default_nettype none

module urxf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            res_valid_o,
  input logic                            res_ready_i,
  input logic                            out_valid_o,
  input logic [urxf_pkg::BYTE_W-1:0]     out_byte_o,
  input logic [urxf_pkg::FIFO_CNT_W-1:0] fifo_count_o,
  input logic                            dropped_o
);
  import urxf_pkg::*;

  // Every accepted word shows its result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> res_valid_o)
    else $error("accepted word produced no result");

  // A dropped byte means the FIFO stayed full through the tick
  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && dropped_o |-> fifo_count_o == FIFO_CNT_W'(RING_DEPTH - 1))
    else $error("byte dropped while FIFO not full");

  // No popped byte, no data
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> out_byte_o == '0)
    else $error("out_byte nonzero without a popped byte");

  // A stalled result holds its byte
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(out_byte_o))
    else $error("stalled result changed");

endmodule

bind uart_receiver_with_ring_fifo urxf_checker u_urxf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .res_valid_o  (res_valid_o),
  .res_ready_i  (res_ready_i),
  .out_valid_o  (out_valid_o),
  .out_byte_o   (out_byte_o),
  .fifo_count_o (fifo_count_o),
  .dropped_o    (dropped_o)
);

`default_nettype wire

// ===== test/urxf_tb_pkg.sv =====
// Scoreboard for the UART receiver with ring FIFO bench: per-tick predictor and result check.
// Depends on urxf_pkg for field widths, FIFO depth and the receive phase encoding.
`timescale 1ns / 1ps

package urxf_tb_pkg;
  import urxf_pkg::*;

  typedef struct {
    bit                  valid;
    bit [BYTE_W-1:0]     data;
    bit [FIFO_CNT_W-1:0] count;
    bit                  drop;
    bit                  busy;
  } tick_result_t;

  class rx_tick_scoreboard;
    tick_result_t       expected_q[$];
    int unsigned        errors;
    bit [PERIOD_W-1:0]  bit_period;
    bit                 last_level;
    urxf_phase_e        rx_phase;
    bit [TICK_W-1:0]    tick_count;
    bit [BIT_IDX_W-1:0] bit_index;
    bit [BYTE_W-1:0]    shift_byte;
    bit [BYTE_W-1:0]    ring[RING_DEPTH];
    int unsigned        wr_idx;
    int unsigned        rd_idx;

    function new();
      errors     = 0;
      bit_period = PERIOD_W'(PERIOD_RST);
      last_level = 1'b1;
      rx_phase   = PH_IDLE;
      tick_count = '0;
      bit_index  = '0;
      shift_byte = '0;
      wr_idx     = 0;
      rd_idx     = 0;
    endfunction

    function int unsigned held();
      return (wr_idx >= rd_idx) ? wr_idx - rd_idx : RING_DEPTH - rd_idx + wr_idx;
    endfunction

    function int unsigned advance(int unsigned idx);
      return (idx + 1 >= RING_DEPTH) ? 0 : idx + 1;
    endfunction

    function int unsigned eff_period();
      return (bit_period < PERIOD_MIN) ? PERIOD_MIN : bit_period;
    endfunction

    function void set_period(bit [PERIOD_W-1:0] value);
      bit_period = value;
    endfunction

    function bit rx_active();
      return rx_phase != PH_IDLE;
    endfunction

    // One sample tick: pop first, then the frame receiver, then the push.
    function void note_word(bit level, bit pop);
      tick_result_t res;
      bit           finished;
      int unsigned  p;
      res      = '{default: 0};
      finished = 1'b0;
      p        = eff_period();
      if (pop && held() != 0) begin
        res.valid = 1'b1;
        res.data  = ring[rd_idx];
        rd_idx    = advance(rd_idx);
      end
      case (rx_phase)
        PH_IDLE: begin
          if (last_level && !level) begin
            rx_phase   = PH_DATA;
            tick_count = TICK_W'(p + p / 3);
            bit_index  = '0;
            shift_byte = '0;
          end
        end
        PH_DATA: begin
          tick_count = tick_count - 1'b1;
          if (tick_count == 0) begin
            shift_byte[bit_index] = level;
            tick_count = TICK_W'(p);
            if (bit_index == BIT_IDX_W'(BYTE_W - 1)) begin
              bit_index = '0;
              rx_phase  = PH_STOP;
            end else begin
              bit_index = bit_index + 1'b1;
            end
          end
        end
        PH_STOP: begin
          tick_count = tick_count - 1'b1;
          if (tick_count == 0) begin
            finished = 1'b1;
            rx_phase = PH_IDLE;
          end
        end
        default: rx_phase = PH_IDLE;
      endcase
      if (finished) begin
        if (held() >= RING_DEPTH - 1) begin
          res.drop = 1'b1;
        end else begin
          ring[wr_idx] = shift_byte;
          wr_idx       = advance(wr_idx);
        end
      end
      last_level = level;
      res.count  = FIFO_CNT_W'(held());
      res.busy   = (rx_phase != PH_IDLE);
      expected_q.push_back(res);
    endfunction

    function void check_result(logic valid, logic [BYTE_W-1:0] data,
                               logic [FIFO_CNT_W-1:0] count, logic drop, logic busy);
      tick_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result word with no sample tick outstanding");
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (valid !== exp_r.valid) begin
        $error("out_valid: expected %0d, got %0d", exp_r.valid, valid);
        errors++;
      end
      if (data !== exp_r.data) begin
        $error("out_byte: expected %0d, got %0d", exp_r.data, data);
        errors++;
      end
      if (count !== exp_r.count) begin
        $error("fifo_count: expected %0d, got %0d", exp_r.count, count);
        errors++;
      end
      if (drop !== exp_r.drop) begin
        $error("dropped: expected %0d, got %0d", exp_r.drop, drop);
        errors++;
      end
      if (busy !== exp_r.busy) begin
        $error("rx_busy: expected %0d, got %0d", exp_r.busy, busy);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== test/uart_receiver_with_ring_fifo_tb.sv =====
// Self-checking bench for the 8N1 UART receiver with ring FIFO: drives sample ticks and pops,
// predicts every result word in a scoreboard and checks it field by field.
// Depends on urxf_pkg, urxf_tb_pkg and the block under test.
`timescale 1ns / 1ps

module uart_receiver_with_ring_fifo_tb;
  import urxf_pkg::*;
  import urxf_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_WORDS = 250;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  rx_level_i  = 1'b1;
  logic                  pop_req_i   = 1'b0;
  logic                  res_valid_o;
  logic                  res_ready_i = 1'b0;
  logic                  out_valid_o;
  logic [BYTE_W-1:0]     out_byte_o;
  logic [FIFO_CNT_W-1:0] fifo_count_o;
  logic                  dropped_o;
  logic                  rx_busy_o;

  rx_tick_scoreboard sb = new();

  // Idle rates in percent; the sender's gap and the receiver's stall are set per phase
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  int unsigned words_sent  = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_sched[4]   = '{0, 53, 0, 18};
  int unsigned stall_sched[4] = '{0, 0, 53, 18};

  uart_receiver_with_ring_fifo u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_level_i   (rx_level_i),
    .pop_req_i    (pop_req_i),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .fifo_count_o (fifo_count_o),
    .dropped_o    (dropped_o),
    .rx_busy_o    (rx_busy_o)
  );

  always #5 clk_i = ~clk_i;

  // Hang guard: end the run if the stimulus or the results stop moving
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the result side at the phase's rate; a zero rate keeps ready high throughout
  always @(posedge clk_i) begin
    res_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Check every result word taken at this edge against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && res_ready_i) begin
      sb.check_result(out_valid_o, out_byte_o, fifo_count_o, dropped_o, rx_busy_o);
    end
  end

  // Offer one word, after a random gap, and hold it until the block takes it.
  // The prediction is made here at the accepting edge, so later decisions see it.
  task automatic send_word(input logic lvl, input logic pop);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < gap_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_level_i <= lvl;
    pop_req_i  <= pop;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(lvl, pop);
    words_sent++;
  endtask

  // Drop valid and hold until every predicted word has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // One APB transfer to the period register: setup cycle, then access until pready
  task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'({REG_BIT_PERIOD, 2'b00});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the bit period once no word is in flight, then read it back. The upper
  // data bits carry junk that the register must ignore.
  task automatic write_period(input logic [PERIOD_W-1:0] value);
    logic [APB_DATA_W-1:0] wdata;
    logic [APB_DATA_W-1:0] rdata;
    wait_drained();
    wdata = $urandom;
    wdata[PERIOD_W-1:0] = value;
    apb_access(1'b1, wdata, rdata);
    sb.set_period(value);
    @(posedge clk_i);
    apb_access(1'b0, '0, rdata);
    if (rdata[PERIOD_W-1:0] !== value) begin
      $error("bit_period: expected %0d, got %0d", value, rdata[PERIOD_W-1:0]);
      sb.errors++;
    end
  endtask

  // Send one 8N1 frame at the current period: start bit, eight data bits LSB first,
  // stop bit lasting until the tick that finishes the byte. Optional faults: a low stop
  // bit, glitches away from the sample points, and a cut after a number of ticks.
  task automatic send_frame(input logic [BYTE_W-1:0] rx_byte, input int unsigned pop_pct,
                            input bit bad_stop, input bit glitch, input bit pop_at_end,
                            input int unsigned cut);
    int unsigned p;
    int unsigned full_len;
    int unsigned len;
    logic        lvl;
    logic        pop;
    p        = sb.eff_period();
    full_len = p + p / 3 + 8 * p + 1;
    len      = (cut != 0 && cut < full_len) ? cut : full_len;
    // The start edge needs the line high on the tick before
    if (!sb.last_level) send_word(1'b1, 1'b0);
    for (int unsigned i = 0; i < len; i++) begin
      if (i < p) lvl = 1'b0;
      else if (i < 9 * p) lvl = rx_byte[i / p - 1];
      else lvl = !bad_stop;
      if (glitch && i != 0 && ((i + p - p / 3) % p) != 0 && $urandom_range(99) < 8) begin
        lvl = !lvl;
      end
      pop = ($urandom_range(99) < pop_pct) || (pop_at_end && i == full_len - 1);
      send_word(lvl, pop);
    end
  endtask

  initial begin
    logic [APB_DATA_W-1:0] rdata;
    int unsigned           phase_end;
    int unsigned           pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of the period register
    apb_access(1'b0, '0, rdata);
    if (rdata[PERIOD_W-1:0] !== PERIOD_W'(PERIOD_RST)) begin
      $error("bit_period: expected %0d, got %0d", PERIOD_RST, rdata[PERIOD_W-1:0]);
      sb.errors++;
    end

    // Pop on an empty FIFO; keep the line high so the slow reset period starts nothing
    send_word(1'b1, 1'b1);
    send_word(1'b1, 1'b0);

    // Extreme bytes at the shortest period; a pop on the finishing tick of the first
    // frame must not see the byte that finishes there
    write_period(PERIOD_W'(PERIOD_MIN));
    send_frame(8'h00, 0, 1'b0, 1'b0, 1'b1, 0);
    send_frame(8'hFF, 0, 1'b0, 1'b0, 1'b0, 0);
    send_frame(8'hA5, 0, 1'b0, 1'b0, 1'b0, 0);
    repeat (4) send_word(1'b1, 1'b1);

    // Period below the minimum acts as the minimum. A low stop bit leaves the line low,
    // so the next low tick is no edge until the line has gone high again.
    write_period(PERIOD_W'(2));
    send_frame(8'h5A, 0, 1'b1, 1'b0, 1'b0, 0);
    send_word(1'b0, 1'b0);
    send_word(1'b1, 1'b0);
    send_frame(8'h3C, 0, 1'b0, 1'b0, 1'b1, 0);
    repeat (2) send_word(1'b1, 1'b1);

    // Period change mid-frame takes effect at the next reload
    write_period(PERIOD_W'(4));
    send_frame(8'hC3, 0, 1'b0, 1'b0, 1'b0, 9);
    write_period(PERIOD_W'(7));
    while (sb.rx_active()) send_word(1'($urandom_range(1)), 1'b0);

    // Widest period value reads back whole; go back to the shortest period
    write_period(16'hFFFF);
    write_period(PERIOD_W'(PERIOD_MIN));

    // Drain everything with the line high and pop once more on empty
    while (sb.held() != 0) send_word(1'b1, 1'b1);
    send_word(1'b1, 1'b1);

    // Random part: mostly well-formed frames with random bytes, periods and pops,
    // the rest broken frames and line noise, under each idling pattern in turn
    for (int k = 0; k < 4; k++) begin
      gap_pct   = gap_sched[k];
      stall_pct = stall_sched[k];
      write_period(PERIOD_W'($urandom_range(1, 10)));
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          send_frame(8'($urandom), 25, 1'b0, ($urandom_range(3) == 0),
                     1'($urandom_range(1)), 0);
        end else if (pick < 87) begin
          send_frame(8'($urandom), 25, 1'($urandom_range(1)), 1'b1,
                     1'($urandom_range(1)), $urandom_range(1, 40));
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_word(1'($urandom_range(1)), 1'($urandom_range(1)));
          end
        end
        // Sometimes change the period, possibly with a frame still in progress
        if ($urandom_range(99) < 8) write_period(PERIOD_W'($urandom_range(1, 12)));
      end
    end

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
